>>> src/rae_pkg.sv
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types and constants for the register ALU execute block.
// ----------------------------------------------------------------------------
package rae_pkg;

	localparam int unsigned DataW  = 16;
	localparam int unsigned RegCnt = 8;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned ImmW   = 8;

	localparam logic [DataW-1:0] RegResetVal = 16'h1234;
	localparam logic [DataW-1:0] ShiftLimit  = 16'd16;

	// compare results
	localparam logic [DataW-1:0] CmpEq   = 16'd0;
	localparam logic [DataW-1:0] CmpGt   = 16'd1;
	localparam logic [DataW-1:0] CmpLt   = 16'd2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_AND = 3'd2,
		OP_OR  = 3'd3,
		OP_XOR = 3'd4,
		OP_SHL = 3'd5,
		OP_SHR = 3'd6,
		OP_CMP = 3'd7
	} op_t;

	typedef struct packed {
		logic            en;
		logic [IdxW-1:0] addr;
		logic [DataW-1:0] data;
	} rf_wr_t;

endpackage

>>> src/rae_if.sv
// ----------------------------------------------------------------------------
// rae_if
// Valid/ready channels carrying instruction words and execution results.
// ----------------------------------------------------------------------------
interface rae_insn_if import rae_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DataW-1:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink   (input valid, input instruction, output ready);
endinterface

interface rae_result_if import rae_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IdxW-1:0]  dest_index;
	logic [DataW-1:0] result_value;

	modport source (output valid, output dest_index, output result_value, input ready);
	modport sink   (input valid, input dest_index, input result_value, output ready);
endinterface

>>> src/rae_regfile.sv
// ----------------------------------------------------------------------------
// rae_regfile
// Eight-entry register file, two registered read ports, one write port.
// Reads see a write in the same cycle; unwritten entries read as the reset value.
// ----------------------------------------------------------------------------
module rae_regfile import rae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IdxW-1:0]  rd_addr_a,
	input  logic [IdxW-1:0]  rd_addr_b,
	input  rf_wr_t           wr,
	output logic [DataW-1:0] rd_data_a,
	output logic [DataW-1:0] rd_data_b
);

	logic [DataW-1:0] mem [RegCnt];
	logic [RegCnt-1:0] written_q;
	logic [DataW-1:0] rd_data_a_q;
	logic [DataW-1:0] rd_data_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr.en) begin
			written_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// write-through so a dependent instruction right behind sees the new value
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr_a) begin
				rd_data_a_q <= wr.data;
			end else if (written_q[rd_addr_a]) begin
				rd_data_a_q <= mem[rd_addr_a];
			end else begin
				rd_data_a_q <= RegResetVal;
			end
			if (wr.en && wr.addr == rd_addr_b) begin
				rd_data_b_q <= wr.data;
			end else if (written_q[rd_addr_b]) begin
				rd_data_b_q <= mem[rd_addr_b];
			end else begin
				rd_data_b_q <= RegResetVal;
			end
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

>>> src/rae_alu.sv
// ----------------------------------------------------------------------------
// rae_alu
// Combinational 16-bit ALU: add, subtract, logic ops, shifts and compare.
// ----------------------------------------------------------------------------
module rae_alu import rae_pkg::*; (
	input  op_t              op,
	input  logic [DataW-1:0] a,
	input  logic [DataW-1:0] b,
	output logic [DataW-1:0] y
);

	logic big_shift;

	assign big_shift = (b >= ShiftLimit);

	always_comb begin
		case (op)
			OP_ADD: y = a + b;
			OP_SUB: y = a - b;
			OP_AND: y = a & b;
			OP_OR:  y = a | b;
			OP_XOR: y = a ^ b;
			OP_SHL: y = big_shift ? '0 : (a << b[3:0]);
			OP_SHR: y = big_shift ? '0 : (a >> b[3:0]);
			OP_CMP: begin
				if (a == b) begin
					y = CmpEq;
				end else if (a > b) begin
					y = CmpGt;
				end else begin
					y = CmpLt;
				end
			end
			default: y = '0;
		endcase
	end

endmodule

>>> src/register_alu_instruction_execute.sv
// ----------------------------------------------------------------------------
// register_alu_instruction_execute
// Executes one instruction per cycle unless stalled, on an eight-register file.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle while input ready is high. The
// operand stage captures the decoded fields and the two register-file
// operands at acceptance; the output register then captures the ALU result
// as it is written back and offers it. Reads forward a write-back of the same
// cycle, so dependent instructions may follow back to back. Input ready drops
// only when both the operand stage and the output register are full and the
// output is stalled. Registers hold 0x1234 after reset; no clearing pass.
module register_alu_instruction_execute import rae_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rae_insn_if.sink    insn,
	rae_result_if.source result
);

	logic             valid_s1;
	logic [IdxW-1:0]  dest_s1;
	op_t              op_s1;
	logic             fmt_s1;
	logic [ImmW-1:0]  imm_s1;
	logic [DataW-1:0] opa_s1;
	logic [DataW-1:0] src_s1;

	logic             valid_s2;
	logic [IdxW-1:0]  dest_s2;
	logic [DataW-1:0] value_s2;

	logic             advance;
	logic             accept;
	logic [DataW-1:0] opb;
	logic [DataW-1:0] alu_y;
	rf_wr_t           rf_wr;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign insn.ready = !valid_s1 || advance;
	assign accept     = insn.valid && insn.ready;

	assign rf_wr.en   = advance;
	assign rf_wr.addr = dest_s1;
	assign rf_wr.data = alu_y;

	rae_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (insn.instruction[15:13]),
		.rd_addr_b (insn.instruction[12:10]),
		.wr        (rf_wr),
		.rd_data_a (opa_s1),
		.rd_data_b (src_s1)
	);

	// immediate shares bits with the source index, format bit picks one
	assign opb = fmt_s1 ? {{(DataW-ImmW){1'b0}}, imm_s1} : src_s1;

	rae_alu u_alu (
		.op (op_s1),
		.a  (opa_s1),
		.b  (opb),
		.y  (alu_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (insn.ready) begin
			valid_s1 <= insn.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dest_s1 <= insn.instruction[15:13];
			op_s1   <= op_t'(insn.instruction[4:2]);
			fmt_s1  <= insn.instruction[0];
			imm_s1  <= insn.instruction[12:5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dest_s2  <= dest_s1;
			value_s2 <= alu_y;
		end
	end

	assign result.valid        = valid_s2;
	assign result.dest_index   = dest_s2;
	assign result.result_value = value_s2;

endmodule

>>> src/rae_checker.sv
// ----------------------------------------------------------------------------
// rae_checker
// Port-level checks of the register ALU execute block, bound to the top level.
// ----------------------------------------------------------------------------
module rae_checker import rae_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [IdxW-1:0]  res_dest,
	input logic [DataW-1:0] res_value
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_dest) && $stable(res_value))
		else $error("result payload changed while stalled");

	// back-pressure on the input only comes from a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid && !res_ready)
		else $error("input blocked without output stall");

	// a fresh result needs an earlier accepted input word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a matching input word");

endmodule

bind register_alu_instruction_execute rae_checker u_rae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (insn.valid),
	.in_ready  (insn.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_dest  (result.dest_index),
	.res_value (result.result_value)
);
